// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define DACD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dacd same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define DACD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dacd next-cycle check failed");

`endif

// ----- design/dacd_pkg.sv -----
`timescale 1ns / 1ps
package dacd_pkg;

  localparam int SYMBOL_DEPTH_DEF  = 1024;
  localparam int PREFIX_DEPTH_DEF  = 1024;
  localparam int HISTORY_DEPTH_DEF = 4096;

  // width that holds any depth in range, for compares
  localparam int IDX_W = 17;

  localparam logic [2:0] OP_LOAD_SYM = 3'd0;
  localparam logic [2:0] OP_LOAD_PFX = 3'd1;
  localparam logic [2:0] OP_START    = 3'd2;
  localparam logic [2:0] OP_SYMBOL   = 3'd3;
  localparam logic [2:0] OP_OFFSET   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_IDX  = 3'd1;
  localparam logic [2:0] ST_BAD_SYM  = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_BAD_OP   = 3'd4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_PFX  = 2'd1;
  localparam logic [1:0] KIND_HIST = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_SYMCNT = 2'd1;
  localparam logic [1:0] REG_PFXLEN = 2'd2;

  localparam logic [31:0] M0_LIT_END  = 32'h0001_0000;
  localparam logic [31:0] M0_CODE_MAX = 32'h0001_007F;
  localparam logic [31:0] M1_LIT_BASE = 32'h0000_0080;
  localparam logic [15:0] M1_LIT_BIAS = 16'h0080;
  localparam logic [6:0]  COPY_BIAS   = 7'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [9:0]  table_index;
    logic [31:0] entry_value;
    logic [12:0] article_length;
    logic [9:0]  symbol_index;
    logic [11:0] start_offset;
  } in_item_t;

  typedef struct packed {
    logic [15:0] first_char;
    logic [15:0] second_char;
    logic [1:0]  char_count;
    logic [3:0]  offset_bits;
    logic [12:0] article_position;
    logic        run_last;
    logic        article_done;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic        encoding_mode;
    logic [10:0] symbol_count;
    logic [10:0] pfx_len;
  } cfg_t;

endpackage

// ----- design/dictionary_article_copy_decoder.sv -----
`timescale 1ns / 1ps
// channel   | handshake                 | payload
// ----------+---------------------------+--------------------------------
// input     | in_valid / in_ready       | in_data   (dacd_pkg::in_item_t)
// result    | out_valid / out_ready     | out_data  (dacd_pkg::out_item_t)
// config    | psel penable pwrite pready| paddr pwdata prdata
//
// Loads are written in idle and give no result. Start, rejected symbols, stray
// offsets and bad opcodes pass decide and the result register; a symbol that
// reads the table also passes the table read. An offset is accepted and planned;
// each character is read from history and written back, each result sent out.
// Reset clears control state only; the three memories are not cleared.
// A full result register stalls the engine; new input waits until it is idle.
module dictionary_article_copy_decoder #(
  parameter int SYMBOL_DEPTH  = dacd_pkg::SYMBOL_DEPTH_DEF,
  parameter int PREFIX_DEPTH  = dacd_pkg::PREFIX_DEPTH_DEF,
  parameter int HISTORY_DEPTH = dacd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dacd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dacd_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  dacd_pkg::cfg_t cfg_r, cfg_nxt;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        dacd_pkg::REG_MODE:   cfg_nxt.encoding_mode = pwdata[0];
        dacd_pkg::REG_SYMCNT: cfg_nxt.symbol_count  = pwdata[10:0];
        dacd_pkg::REG_PFXLEN: cfg_nxt.pfx_len       = pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dacd_pkg::REG_MODE:   prdata = 32'(cfg_r.encoding_mode);
      dacd_pkg::REG_SYMCNT: prdata = 32'(cfg_r.symbol_count);
      dacd_pkg::REG_PFXLEN: prdata = 32'(cfg_r.pfx_len);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dacd_ctrl #(
    .SYMBOL_DEPTH(SYMBOL_DEPTH),
    .PREFIX_DEPTH(PREFIX_DEPTH),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule

// ----- design/dacd_ram.sv -----
`timescale 1ns / 1ps
module dacd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/dacd_ctrl.sv -----
`timescale 1ns / 1ps
module dacd_ctrl #(
  parameter int SYMBOL_DEPTH  = dacd_pkg::SYMBOL_DEPTH_DEF,
  parameter int PREFIX_DEPTH  = dacd_pkg::PREFIX_DEPTH_DEF,
  parameter int HISTORY_DEPTH = dacd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dacd_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  dacd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dacd_pkg::out_item_t out_data
);

  localparam int SAW = $clog2(SYMBOL_DEPTH);
  localparam int PAW = $clog2(PREFIX_DEPTH);
  localparam int HAW = $clog2(HISTORY_DEPTH);
  localparam int PW  = $clog2(HISTORY_DEPTH + 1);
  localparam int XW  = dacd_pkg::IDX_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SYM  = 6'b000010,
    S_PLAN = 6'b000100,
    S_RD   = 6'b001000,
    S_WR   = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [PW-1:0]       tgt_r, tgt_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [6:0]          len_r, len_nxt;
  logic [XW-1:0]       src_r, src_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  logic                half_r, half_nxt;
  logic                hist_r, hist_nxt;
  logic [15:0]         c0_r, c0_nxt;
  logic [2:0]          st_r, st_nxt;
  logic                more_r, more_nxt;
  dacd_pkg::out_item_t resp_r, resp_nxt;
  logic                out_valid_r, out_valid_nxt;
  dacd_pkg::out_item_t out_data_r, out_data_nxt;

  logic                sym_we, pfx_we, hist_we;
  logic [SAW-1:0]      sym_waddr, sym_raddr;
  logic [PAW-1:0]      pfx_waddr, pfx_raddr;
  logic [HAW-1:0]      hist_waddr, hist_raddr;
  logic [15:0]         hist_wdata;
  logic [31:0]         sym_rdata;
  logic [15:0]         pfx_rdata, hist_rdata;

  logic [XW-1:0]       tidx_x, sidx_x, alen_x, pos_x, pos_inc_x, tgt_x;
  logic [XW-1:0]       limit_x, avail_x, len_x, nsrc_x, room_x, plen_x;
  logic [6:0]          n_copy;
  logic [2:0]          n_st;
  logic [15:0]         ch;
  logic                can_load, last_char;

  function automatic logic [4:0] bit_len(input logic [XW-1:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < XW; i++) begin
      if (v[i]) begin
        n = 5'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic dacd_pkg::out_item_t mk_resp(
    input logic [15:0] c0, input logic [15:0] c1, input logic [1:0] cnt,
    input logic [3:0] bits, input logic [XW-1:0] p, input logic last,
    input logic done, input logic [2:0] st);
    dacd_pkg::out_item_t r;
    r.first_char       = c0;
    r.second_char      = c1;
    r.char_count       = cnt;
    r.offset_bits      = bits;
    r.article_position = p[12:0];
    r.run_last         = last;
    r.article_done     = done;
    r.status           = st;
    return r;
  endfunction

  dacd_ram #(.WIDTH(32), .DEPTH(SYMBOL_DEPTH)) u_sym_ram (
    .clk(clk), .we(sym_we), .waddr(sym_waddr), .wdata(in_data.entry_value),
    .raddr(sym_raddr), .rdata(sym_rdata)
  );

  dacd_ram #(.WIDTH(16), .DEPTH(PREFIX_DEPTH)) u_pfx_ram (
    .clk(clk), .we(pfx_we), .waddr(pfx_waddr), .wdata(in_data.entry_value[15:0]),
    .raddr(pfx_raddr), .rdata(pfx_rdata)
  );

  dacd_ram #(.WIDTH(16), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign can_load  = !out_valid_r || out_ready;

  assign tidx_x    = XW'(in_data.table_index);
  assign sidx_x    = XW'(in_data.symbol_index);
  assign alen_x    = XW'(in_data.article_length);
  assign pos_x     = XW'(pos_r);
  assign pos_inc_x = pos_x + XW'(1);
  assign tgt_x     = XW'(tgt_r);
  assign plen_x    = XW'(cfg.pfx_len);
  assign len_x     = XW'(len_r);

  assign sym_waddr  = tidx_x[SAW-1:0];
  assign sym_raddr  = sidx_x[SAW-1:0];
  assign pfx_waddr  = tidx_x[PAW-1:0];
  assign pfx_raddr  = src_r[PAW-1:0];
  assign hist_raddr = src_r[HAW-1:0];
  assign hist_waddr = pos_x[HAW-1:0];

  // copy plan: characters the source allows, then the room left in history
  always_comb begin
    limit_x = (plen_x < XW'(PREFIX_DEPTH)) ? plen_x : XW'(PREFIX_DEPTH);
    if (hist_r) begin
      avail_x = (src_r < pos_x) ? '1 : '0;
    end else begin
      avail_x = (src_r < limit_x) ? (limit_x - src_r) : '0;
    end
    nsrc_x = (len_x < avail_x) ? len_x : avail_x;
    room_x = XW'(HISTORY_DEPTH) - pos_x;
    if (nsrc_x > room_x) begin
      n_copy = room_x[6:0];
      n_st   = dacd_pkg::ST_OVERFLOW;
    end else begin
      n_copy = nsrc_x[6:0];
      n_st   = dacd_pkg::ST_OK;
    end
  end

  assign ch        = hist_r ? hist_rdata : pfx_rdata;
  assign last_char = (cnt_r == 7'd1);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    tgt_nxt       = tgt_r;
    kind_nxt      = kind_r;
    len_nxt       = len_r;
    src_nxt       = src_r;
    cnt_nxt       = cnt_r;
    half_nxt      = half_r;
    hist_nxt      = hist_r;
    c0_nxt        = c0_r;
    st_nxt        = st_r;
    more_nxt      = more_r;
    resp_nxt      = resp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sym_we        = 1'b0;
    pfx_we        = 1'b0;
    hist_we       = 1'b0;
    hist_wdata    = ch;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          more_nxt = 1'b0;
          resp_nxt = mk_resp('0, '0, 2'd0, 4'd0, pos_x, 1'b1, pos_r >= tgt_r,
                             dacd_pkg::ST_BAD_OP);
          state_nxt = S_RESP;
          case (in_data.opcode)
            dacd_pkg::OP_LOAD_SYM: begin
              sym_we    = (tidx_x < XW'(SYMBOL_DEPTH));
              state_nxt = S_IDLE;
            end
            dacd_pkg::OP_LOAD_PFX: begin
              pfx_we    = (tidx_x < XW'(PREFIX_DEPTH));
              state_nxt = S_IDLE;
            end
            dacd_pkg::OP_START: begin
              pos_nxt  = '0;
              tgt_nxt  = (alen_x < XW'(HISTORY_DEPTH)) ? alen_x[PW-1:0] :
                         PW'(HISTORY_DEPTH);
              kind_nxt = dacd_pkg::KIND_NONE;
              len_nxt  = '0;
              resp_nxt = mk_resp('0, '0, 2'd0, 4'd0, '0, 1'b1, tgt_nxt == '0,
                                 dacd_pkg::ST_OK);
            end
            dacd_pkg::OP_SYMBOL: begin
              if (kind_r != dacd_pkg::KIND_NONE || pos_r >= tgt_r) begin
                resp_nxt.status = dacd_pkg::ST_BAD_OP;
              end else if (sidx_x >= XW'(cfg.symbol_count) ||
                           sidx_x >= XW'(SYMBOL_DEPTH)) begin
                resp_nxt.status = dacd_pkg::ST_BAD_IDX;
              end else begin
                state_nxt = S_SYM;
              end
            end
            dacd_pkg::OP_OFFSET: begin
              if (kind_r != dacd_pkg::KIND_NONE) begin
                src_nxt   = XW'(in_data.start_offset);
                hist_nxt  = (kind_r == dacd_pkg::KIND_HIST);
                state_nxt = S_PLAN;
              end
            end
            default: begin
              resp_nxt.status = dacd_pkg::ST_BAD_OP;
            end
          endcase
        end
      end

      S_SYM: begin
        state_nxt = S_RESP;
        more_nxt  = 1'b0;
        if (!cfg.encoding_mode && sym_rdata > dacd_pkg::M0_CODE_MAX) begin
          resp_nxt = mk_resp('0, '0, 2'd0, 4'd0, pos_x, 1'b1, pos_r >= tgt_r,
                             dacd_pkg::ST_BAD_SYM);
        end else if (( cfg.encoding_mode && sym_rdata < dacd_pkg::M1_LIT_BASE) ||
                     (!cfg.encoding_mode && sym_rdata >= dacd_pkg::M0_LIT_END)) begin
          // copy symbol: length is the low six bits plus three in both codings
          kind_nxt = sym_rdata[6] ? dacd_pkg::KIND_HIST : dacd_pkg::KIND_PFX;
          len_nxt  = 7'(sym_rdata[5:0]) + dacd_pkg::COPY_BIAS;
          resp_nxt = mk_resp('0, '0, 2'd0,
                             4'(bit_len(sym_rdata[6] ? tgt_x : plen_x)),
                             pos_x, 1'b1, pos_r >= tgt_r, dacd_pkg::ST_OK);
        end else if (pos_x >= XW'(HISTORY_DEPTH)) begin
          resp_nxt = mk_resp('0, '0, 2'd0, 4'd0, pos_x, 1'b1, pos_r >= tgt_r,
                             dacd_pkg::ST_OVERFLOW);
        end else begin
          hist_wdata = cfg.encoding_mode ? (sym_rdata[15:0] - dacd_pkg::M1_LIT_BIAS) :
                       sym_rdata[15:0];
          hist_we    = 1'b1;
          pos_nxt    = pos_inc_x[PW-1:0];
          resp_nxt   = mk_resp(hist_wdata, '0, 2'd1, 4'd0, pos_inc_x, 1'b1,
                               pos_inc_x >= tgt_x, dacd_pkg::ST_OK);
        end
      end

      S_PLAN: begin
        kind_nxt = dacd_pkg::KIND_NONE;
        len_nxt  = '0;
        cnt_nxt  = n_copy;
        st_nxt   = n_st;
        half_nxt = 1'b0;
        if (n_copy == '0) begin
          more_nxt  = 1'b0;
          resp_nxt  = mk_resp('0, '0, 2'd0, 4'd0, pos_x, 1'b1, pos_r >= tgt_r, n_st);
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_RD;
        end
      end

      S_RD: begin
        state_nxt = S_WR;
      end

      S_WR: begin
        hist_we = 1'b1;
        pos_nxt = pos_inc_x[PW-1:0];
        src_nxt = src_r + XW'(1);
        cnt_nxt = cnt_r - 7'd1;
        if (!half_r && !last_char) begin
          c0_nxt    = ch;
          half_nxt  = 1'b1;
          state_nxt = S_RD;
        end else begin
          half_nxt  = 1'b0;
          more_nxt  = !last_char;
          state_nxt = S_RESP;
          if (half_r) begin
            resp_nxt = mk_resp(c0_r, ch, 2'd2, 4'd0, pos_inc_x, last_char,
                               pos_inc_x >= tgt_x, last_char ? st_r : dacd_pkg::ST_OK);
          end else begin
            resp_nxt = mk_resp(ch, '0, 2'd1, 4'd0, pos_inc_x, 1'b1,
                               pos_inc_x >= tgt_x, st_r);
          end
        end
      end

      S_RESP: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = resp_r;
          state_nxt     = more_r ? S_RD : S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      tgt_r       <= '0;
      kind_r      <= dacd_pkg::KIND_NONE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
      more_r      <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      tgt_r       <= tgt_nxt;
      kind_r      <= kind_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      more_r      <= more_nxt;
      half_r      <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    cnt_r      <= cnt_nxt;
    hist_r     <= hist_nxt;
    c0_r       <= c0_nxt;
    st_r       <= st_nxt;
    resp_r     <= resp_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- design/dacd_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dacd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input dacd_pkg::out_item_t out_data
);

  // hold a stalled result
  `DACD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // results inside a copy always carry a full pair
  `DACD_ASSERT_IMP(a_mid_pair, out_valid && !out_data.run_last, out_data.char_count == 2'd2)
  // an error ends the transaction
  `DACD_ASSERT_IMP(a_err_last, out_valid && out_data.status != dacd_pkg::ST_OK, out_data.run_last)
  // more results follow, so no new input is taken
  `DACD_ASSERT_IMP(a_busy_copy, out_valid && !out_data.run_last, !in_ready)

endmodule

bind dictionary_article_copy_decoder dacd_checker u_dacd_checker (.*);

// ----- sim/dictionary_article_copy_decoder_tb.sv -----
`timescale 1ns / 1ps
module dictionary_article_copy_decoder_tb;

  localparam int SYM_D  = dacd_pkg::SYMBOL_DEPTH_DEF;
  localparam int PFX_D  = dacd_pkg::PREFIX_DEPTH_DEF;
  localparam int HIST_D = dacd_pkg::HISTORY_DEPTH_DEF;
  localparam int TAB_N  = 8;
  localparam int PFX_N  = 16;

  // opcodes the decoder does not know
  localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  dacd_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  dacd_pkg::out_item_t out_data;
  logic                psel, penable, pwrite;
  logic [3:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  dictionary_article_copy_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // decoder shadow state
  logic [31:0] sym_tbl [SYM_D];
  logic [15:0] pfx_mem [PFX_D];
  logic [15:0] hist_mem [HIST_D];
  int unsigned pos, tgt, pend_kind, pend_len;
  int unsigned mode_r, symcnt_r, pfxlen_r;

  dacd_pkg::in_item_t  pending_items[$];
  dacd_pkg::out_item_t expected_results[$];
  int        errors, results_seen, items_sent, copies_done;
  int        burst_left, gap_left;
  bit        in_taken;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int unsigned bit_length(int unsigned v);
    int unsigned n;
    n = 0;
    while (v != 0) begin
      n++;
      v >>= 1;
    end
    return n;
  endfunction

  function automatic dacd_pkg::out_item_t make_result(int unsigned c0, int unsigned c1,
      int unsigned cnt, int unsigned bits, bit last, logic [2:0] st);
    dacd_pkg::out_item_t r;
    r.first_char = c0[15:0];
    r.second_char = c1[15:0];
    r.char_count = cnt[1:0];
    r.offset_bits = bits[3:0];
    r.article_position = pos[12:0];
    r.run_last = last;
    r.article_done = (pos >= tgt);
    r.status = st;
    return r;
  endfunction

  function automatic void decode_symbol(int unsigned idx);
    int unsigned s, kind, len;
    kind = 0;
    len = 0;
    if (pend_kind != 0 || pos >= tgt) begin
      expected_results.push_back(make_result(0, 0, 0, 0, 1, dacd_pkg::ST_BAD_OP));
      return;
    end
    if (idx >= symcnt_r || idx >= SYM_D) begin
      expected_results.push_back(make_result(0, 0, 0, 0, 1, dacd_pkg::ST_BAD_IDX));
      return;
    end
    s = sym_tbl[idx];
    if (mode_r == 0) begin
      if (s < 32'h10000) kind = 0;
      else if (s < 32'h10040) begin kind = 1; len = s - 32'hFFFD; end
      else if (s <= 32'h1007F) begin kind = 2; len = s - 32'h1003D; end
      else begin
        expected_results.push_back(make_result(0, 0, 0, 0, 1, dacd_pkg::ST_BAD_SYM));
        return;
      end
    end else begin
      if (s <= 32'h3F) begin kind = 1; len = s + 3; end
      else if (s < 32'h80) begin kind = 2; len = s - 32'h3D; end
      else begin kind = 0; s = (s - 32'h80) & 32'hFFFF; end
    end
    if (kind == 0) begin
      if (pos >= HIST_D) begin
        expected_results.push_back(make_result(0, 0, 0, 0, 1, dacd_pkg::ST_OVERFLOW));
        return;
      end
      hist_mem[pos] = s[15:0];
      pos++;
      expected_results.push_back(make_result(s, 0, 1, 0, 1, dacd_pkg::ST_OK));
      return;
    end
    pend_kind = kind;
    pend_len = len;
    expected_results.push_back(make_result(0, 0, 0,
      bit_length(kind == 1 ? pfxlen_r : tgt), 1, dacd_pkg::ST_OK));
  endfunction

  function automatic void run_copy(int unsigned start);
    int unsigned lim, nch, src, k;
    logic [2:0]  st;
    logic [15:0] c, p0, p1;
    dacd_pkg::out_item_t r;
    nch = 0; k = 0; st = dacd_pkg::ST_OK; p0 = 0;
    if (pend_kind == 0) begin
      expected_results.push_back(make_result(0, 0, 0, 0, 1, dacd_pkg::ST_BAD_OP));
      return;
    end
    copies_done++;
    lim = pfxlen_r < PFX_D ? pfxlen_r : PFX_D;
    for (int unsigned i = 0; i < pend_len; i++) begin
      src = start + i;
      if (pend_kind == 1) begin
        if (src >= lim) break;
        c = pfx_mem[src];
      end else begin
        if (src >= pos) break;
        c = hist_mem[src];
      end
      if (pos >= HIST_D) begin
        st = dacd_pkg::ST_OVERFLOW;
        break;
      end
      hist_mem[pos] = c;
      pos++;
      if (nch == 0) begin
        p0 = c;
        nch = 1;
      end else begin
        p1 = c;
        expected_results.push_back(make_result(p0, p1, 2, 0, 0, dacd_pkg::ST_OK));
        k++;
        nch = 0;
      end
    end
    pend_kind = 0;
    pend_len = 0;
    if (nch != 0 || k == 0) begin
      expected_results.push_back(make_result(nch != 0 ? p0 : 0, 0, nch, 0, 1, st));
    end else begin
      r = expected_results.pop_back();
      r.run_last = 1'b1;
      r.status = st;
      expected_results.push_back(r);
    end
  endfunction

  function automatic void predict_item(dacd_pkg::in_item_t it);
    case (it.opcode)
      dacd_pkg::OP_LOAD_SYM: begin
        sym_tbl[it.table_index] = it.entry_value;
      end
      dacd_pkg::OP_LOAD_PFX: begin
        pfx_mem[it.table_index] = it.entry_value[15:0];
      end
      dacd_pkg::OP_START: begin
        pos = 0;
        tgt = it.article_length < HIST_D ? it.article_length : HIST_D;
        pend_kind = 0;
        pend_len = 0;
        expected_results.push_back(make_result(0, 0, 0, 0, 1, dacd_pkg::ST_OK));
      end
      dacd_pkg::OP_SYMBOL: decode_symbol(it.symbol_index);
      dacd_pkg::OP_OFFSET: run_copy(it.start_offset);
      default: expected_results.push_back(make_result(0, 0, 0, 0, 1, dacd_pkg::ST_BAD_OP));
    endcase
  endfunction

  // driver: bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold until accepted
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      in_data <= pending_items.pop_front();
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(12, 1);
        gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5, 1);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall pattern: alternating open and stalling phases
  int stall_phase;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rst_n) out_ready <= 1'b0;
    else if (stall_phase[6]) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(2, 0) != 0);
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      predict_item(in_data);
      items_sent++;
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        dacd_pkg::out_item_t e;
        e = expected_results.pop_front();
        if (e !== out_data) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  task automatic cfg_write(logic [1:0] reg_id, int unsigned value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_id, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (reg_id)
      dacd_pkg::REG_MODE:   mode_r = value & 1;
      dacd_pkg::REG_SYMCNT: symcnt_r = value & 32'h7FF;
      default:              pfxlen_r = value & 32'h7FF;
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic dacd_pkg::in_item_t mk(logic [2:0] op);
    dacd_pkg::in_item_t it;
    it = '0;
    it.opcode = op;
    it.table_index = 10'($urandom);
    it.entry_value = $urandom;
    it.article_length = 13'($urandom);
    it.symbol_index = 10'($urandom);
    it.start_offset = 12'($urandom);
    return it;
  endfunction

  task automatic push_load(logic [2:0] op, int unsigned idx, logic [31:0] v);
    dacd_pkg::in_item_t it;
    it = mk(op);
    it.table_index = 10'(idx);
    it.entry_value = v;
    pending_items.push_back(it);
  endtask

  task automatic push_start(int unsigned len);
    dacd_pkg::in_item_t it;
    it = mk(dacd_pkg::OP_START);
    it.article_length = 13'(len);
    pending_items.push_back(it);
  endtask

  task automatic push_symbol(int unsigned idx);
    dacd_pkg::in_item_t it;
    it = mk(dacd_pkg::OP_SYMBOL);
    it.symbol_index = 10'(idx);
    pending_items.push_back(it);
  endtask

  task automatic push_offset(int unsigned off);
    dacd_pkg::in_item_t it;
    it = mk(dacd_pkg::OP_OFFSET);
    it.start_offset = 12'(off);
    pending_items.push_back(it);
  endtask

  // drain and let the engine settle before a register write
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // symbol word encoding a given kind for the active mode
  function automatic logic [31:0] sym_word(int unsigned kind, int unsigned len,
      logic [15:0] ch);
    if (mode_r == 0) begin
      if (kind == 0) return {16'h0, ch};
      if (kind == 1) return 32'hFFFD + len;
      return 32'h1003D + len;
    end
    if (kind == 0) return 32'h80 + ch;
    if (kind == 1) return len - 3;
    return 32'h3D + len;
  endfunction

  // fill the first n table slots with a mix of literals and copies
  task automatic load_table(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      int unsigned k;
      k = $urandom_range(2, 0);
      push_load(dacd_pkg::OP_LOAD_SYM, i,
                sym_word(k, $urandom_range(66, 3), 16'($urandom)));
    end
  endtask

  task automatic random_article(int unsigned nsyms, int unsigned tab_n);
    push_start($urandom_range(3, 0) == 0 ? $urandom_range(8191, 0)
                                        : $urandom_range(200, 1));
    for (int unsigned i = 0; i < nsyms; i++) begin
      int unsigned r;
      r = $urandom_range(19, 0);
      if (r == 0) pending_items.push_back(mk(3'($urandom_range(OP_UNKNOWN_HI,
                                                               OP_UNKNOWN_LO))));
      else if (r == 1) push_offset($urandom);
      else begin
        int unsigned idx;
        idx = (r == 2) ? $urandom_range(1023, 0) : $urandom_range(tab_n - 1, 0);
        if (idx < tab_n || idx >= symcnt_r) begin
          push_symbol(idx);
          if ($urandom_range(9, 0) != 0)
            push_offset($urandom_range(4, 0) == 0 ? $urandom_range(4095, 0)
                                                 : $urandom_range(40, 0));
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    in_taken = 1'b0;
    out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    pos = 0; tgt = 0; pend_kind = 0; pend_len = 0;
    mode_r = 0; symcnt_r = 0; pfxlen_r = 0;
    errors = 0; results_seen = 0; items_sent = 0; copies_done = 0;
    burst_left = 0; gap_left = 0; stall_phase = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // with nothing valid: symbols when done, stray offset, bad opcodes
    push_symbol(0);
    push_start(0);
    push_symbol(0);
    push_offset(12'hFFF);
    pending_items.push_back(mk(OP_UNKNOWN_LO));
    pending_items.push_back(mk(OP_UNKNOWN_HI));
    push_load(dacd_pkg::OP_LOAD_SYM, 1023, 32'h0001_0080);
    push_load(dacd_pkg::OP_LOAD_PFX, 1023, 32'hFFFF_FFFF);
    wait_idle();

    // mode 0 directed
    cfg_write(dacd_pkg::REG_SYMCNT, 1024);
    cfg_write(dacd_pkg::REG_PFXLEN, 8);
    for (int unsigned i = 0; i < 8; i++)
      push_load(dacd_pkg::OP_LOAD_PFX, i, 32'h1234_0000 + i);
    push_load(dacd_pkg::OP_LOAD_SYM, 0, 32'h0000_FFFF);
    push_load(dacd_pkg::OP_LOAD_SYM, 1, 32'h0001_0000);
    push_load(dacd_pkg::OP_LOAD_SYM, 2, 32'h0001_003F);
    push_load(dacd_pkg::OP_LOAD_SYM, 3, 32'h0001_007F);
    push_load(dacd_pkg::OP_LOAD_SYM, 4, 32'h0001_0040);
    push_load(dacd_pkg::OP_LOAD_SYM, 5, 32'hFFFF_FFFF);
    push_start(8191);
    push_symbol(0);
    push_symbol(1); push_offset(0);       // prefix copy of 3
    push_symbol(2); push_offset(4);       // stops at prefix end
    push_symbol(3); push_offset(1);       // overlapping history copy
    push_symbol(4); push_symbol(4);       // symbol while copy pending
    push_offset(4095);                    // empty copy
    push_symbol(5);
    push_symbol(1023);
    wait_idle();

    // mode 1, short prefix
    cfg_write(dacd_pkg::REG_MODE, 1);
    cfg_write(dacd_pkg::REG_PFXLEN, 5);
    cfg_write(dacd_pkg::REG_SYMCNT, 6);
    push_load(dacd_pkg::OP_LOAD_SYM, 0, 32'h0000_0080);
    push_load(dacd_pkg::OP_LOAD_SYM, 1, 32'hFFFF_FFFF);
    push_load(dacd_pkg::OP_LOAD_SYM, 2, 32'h0000_0000);
    push_load(dacd_pkg::OP_LOAD_SYM, 3, 32'h0000_003F);
    push_load(dacd_pkg::OP_LOAD_SYM, 4, 32'h0000_0040);
    push_load(dacd_pkg::OP_LOAD_SYM, 5, 32'h0000_007F);
    push_start(3);
    push_symbol(0);
    push_symbol(2); push_offset(1);
    push_symbol(1);
    push_symbol(6);
    wait_idle();

    // random phases over several register settings; prefix reads stay in the loaded part
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(dacd_pkg::REG_MODE, ph % 2);
      cfg_write(dacd_pkg::REG_SYMCNT, (ph == 3) ? 0 : $urandom_range(TAB_N, 4));
      cfg_write(dacd_pkg::REG_PFXLEN, (ph == 2) ? 0 : $urandom_range(PFX_N, 1));
      if (ph == 0) begin
        for (int unsigned i = 0; i < PFX_N; i++)
          push_load(dacd_pkg::OP_LOAD_PFX, i, $urandom);
      end
      load_table(TAB_N);
      random_article(5, TAB_N);
      wait_idle();
    end

    $display("Covered %0d input transactions, %0d results, %0d copies executed.",
      items_sent, results_seen, copies_done);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/dacd_pkg.sv
design/dacd_ram.sv
design/dacd_ctrl.sv
design/dictionary_article_copy_decoder.sv
design/dacd_checker.sv
sim/dictionary_article_copy_decoder_tb.sv
